// ===== design/bprle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-plane RLE encoder package
// Shared run and burst types and the constants of the run code format.
// ----------------------------------------------------------------------------
package bprle_pkg;

   // Width of a run length and of one byte.
   localparam int LEN_W  = 15;
   localparam int BYTE_W = 8;

   // Longest run that fits the short two-byte code.
   localparam logic [LEN_W-1:0] SHORT_MAX = 15'd127;

   // Marker bit on the first byte of a long run code.
   localparam logic [BYTE_W-1:0] LONG_MARK = 8'h80;

   // One closed run: its length and its byte.
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] val;
   } run_type;

   // Everything one input word produces: one or two runs and the plane end mark.
   typedef struct packed {
      run_type first;
      logic    has_second;
      run_type second;
      logic    plane_end;
   } burst_type;

endpackage

// ===== design/bprle_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-plane RLE front end
// Keeps the open run, accepts input words and turns each word that closes
// runs into a burst record of the runs it closes.
// ----------------------------------------------------------------------------
module bprle_front #(
   parameter int MAX_RUN = 32767
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [bprle_pkg::BYTE_W-1:0] in_byte,
   input  logic                       in_end,
   input  logic                       queue_full,
   output logic                       in_ready,
   output logic                       push,
   output bprle_pkg::burst_type       push_burst
);
   import bprle_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RUN);

   logic [BYTE_W-1:0] run_value_ff, run_value_in;
   logic [LEN_W-1:0]  run_length_ff, run_length_in;
   logic [LEN_W-1:0]  len_mid;
   logic [LEN_W-1:0]  len_inc;
   logic [BYTE_W-1:0] val_mid;
   logic              closed_valid;
   run_type           closed_run;
   logic              flush;
   logic              accept;
   burst_type         burst;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign len_inc  = run_length_ff + LEN_W'(1);

   // Classify the word against the open run.
   always_comb begin
      len_mid      = run_length_ff;
      val_mid      = run_value_ff;
      closed_valid = 1'b0;
      closed_run   = '{len: run_length_ff, val: run_value_ff};
      if (run_length_ff == '0) begin
         val_mid = in_byte;
         len_mid = LEN_W'(1);
      end else if (in_byte == run_value_ff) begin
         if (len_inc >= MAX_LEN) begin
            closed_valid = 1'b1;
            closed_run   = '{len: len_inc, val: run_value_ff};
            len_mid      = '0;
         end else begin
            len_mid = len_inc;
         end
      end else begin
         closed_valid = 1'b1;
         val_mid      = in_byte;
         len_mid      = LEN_W'(1);
      end
      flush = in_end && (len_mid != '0);
   end

   // Pack the closed and flushed runs into one burst record.
   always_comb begin
      burst            = '0;
      burst.plane_end  = in_end;
      if (closed_valid) begin
         burst.first = closed_run;
         if (flush) begin
            burst.has_second = 1'b1;
            burst.second     = '{len: len_mid, val: val_mid};
         end
      end else begin
         burst.first = '{len: len_mid, val: val_mid};
      end
      push_burst    = burst;
      push          = accept && (closed_valid || flush);
      run_value_in  = accept ? val_mid : run_value_ff;
      run_length_in = accept ? (flush ? '0 : len_mid) : run_length_ff;
   end

   // Open run state.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= '0;
         run_length_ff <= '0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
      end
   end

endmodule

// ===== design/bprle_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-plane RLE burst queue
// Two-entry queue of burst records between the front end and the byte emitter.
// ----------------------------------------------------------------------------
module bprle_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bprle_pkg::burst_type push_burst,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output bprle_pkg::burst_type head
);
   import bprle_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   burst_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; no reset needed for payload.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_burst;
      end
   end

endmodule

// ===== design/bprle_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-plane RLE byte emitter
// Walks the burst at the head of the queue and sends its code bytes one word
// per cycle through an output register while out_ready allows.
// ----------------------------------------------------------------------------
module bprle_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_empty,
   input  bprle_pkg::burst_type         head,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [bprle_pkg::BYTE_W-1:0] out_byte,
   output logic                         out_plane_done,
   output logic                         out_last
);
   import bprle_pkg::*;

   localparam int STEP_W = 3;

   // Code byte at position pos of one run.
   function automatic logic [BYTE_W-1:0] run_byte(run_type r, logic [1:0] pos);
      logic is_long;
      logic [BYTE_W-1:0] b;
      is_long = (r.len > SHORT_MAX);
      b = r.val;
      if (is_long) begin
         case (pos)
            2'd0:    b = LONG_MARK | BYTE_W'(r.len[LEN_W-1:BYTE_W]);
            2'd1:    b = r.len[BYTE_W-1:0];
            default: b = r.val;
         endcase
      end else if (pos == 2'd0) begin
         b = r.len[BYTE_W-1:0];
      end
      return b;
   endfunction

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              done_ff, done_in;
   logic              last_ff, last_in;
   logic [STEP_W-1:0] n0, n1, total;
   logic [STEP_W-1:0] pos;
   logic              in_second;
   logic              is_last;
   logic              load;

   // Position of the current byte inside the burst.
   always_comb begin
      n0        = (head.first.len > SHORT_MAX) ? STEP_W'(3) : STEP_W'(2);
      n1        = !head.has_second ? '0 :
                  ((head.second.len > SHORT_MAX) ? STEP_W'(3) : STEP_W'(2));
      total     = n0 + n1;
      in_second = (step_ff >= n0);
      pos       = in_second ? step_ff - n0 : step_ff;
      is_last   = (step_ff == total - STEP_W'(1));
   end

   assign load = !queue_empty && (!valid_ff || out_ready);
   assign pop  = load && is_last;

   // Output register and step counter.
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      done_in  = done_ff;
      last_in  = last_ff;
      step_in  = step_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = in_second ? run_byte(head.second, pos[1:0])
                              : run_byte(head.first, pos[1:0]);
         last_in  = is_last;
         done_in  = is_last && head.plane_end;
         step_in  = is_last ? '0 : step_ff + STEP_W'(1);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      done_ff <= done_in;
      last_ff <= last_in;
   end

   assign out_valid      = valid_ff;
   assign out_byte       = byte_ff;
   assign out_plane_done = done_ff;
   assign out_last       = last_ff;

endmodule

// ===== design/byte_plane_rle_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-plane run-length encoder
// Encodes a stream of plane bytes into runs with 15-bit lengths.
// ----------------------------------------------------------------------------
// Each input word carries one byte of a channel plane, with tlast on the
// plane's last byte. The front end takes a word in the cycle it arrives unless
// the queue is full, and records the runs it closes in a two-entry queue; the
// emitter then sends the code bytes at one word per cycle while rsp_tready
// allows. A run of up to 127 bytes is sent as [length, value], a longer one as
// [0x80 | length high, length low, value]; a run reaching MAX_RUN closes at
// once. An input word causes 0, 2, 3, 4 or 5 output words, so the sustained
// rate is set by the single-byte output port: when every byte differs from
// the last, each input word causes two output words. rsp_tlast marks the last
// code byte of a plane, rsp_tuser the last code byte caused by one input word.
// ----------------------------------------------------------------------------
module byte_plane_rle_encoder #(
   parameter int MAX_RUN = 32767
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // plane_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] code_byte
   output logic       rsp_tlast,   // plane_done
   output logic       rsp_tuser    // [0] last_of_burst
);
   import bprle_pkg::*;

   logic      push;
   burst_type push_burst;
   logic      queue_full;
   logic      queue_empty;
   logic      pop;
   burst_type head;

   bprle_front #(
      .MAX_RUN(MAX_RUN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_end     (req_tlast),
      .queue_full (queue_full),
      .in_ready   (req_tready),
      .push       (push),
      .push_burst (push_burst)
   );

   bprle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   bprle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .head           (head),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (rsp_tdata),
      .out_plane_done (rsp_tlast),
      .out_last       (rsp_tuser)
   );

endmodule
